### rtl/fac_pkg.sv
// fac_pkg: shared types and constants for the frustum box-culling block.
// No dependencies; every other file imports it.
package fac_pkg;

  localparam int FIELD_W   = 32;  // width of one box coordinate field
  localparam int SLOT_W    = 32;  // width of one matrix entry slot in a register
  localparam int CFG_W     = 64;  // configuration register width
  localparam int CFG_IDX_W = 8;   // configuration index width on the port
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int N_AXES    = 3;
  localparam int MAT_DIM   = 4;
  localparam int N_PLANES  = 6;

  // Identity matrix in Q16.16
  localparam logic [CFG_W-1:0] MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef enum logic [2:0] {
    PL_LEFT, PL_RIGHT, PL_BOTTOM, PL_TOP, PL_NEAR, PL_FAR
  } fac_plane_t;

  // One box travelling down the chain, with the running verdict
  typedef struct packed {
    logic [N_AXES-1:0][FIELD_W-1:0] lo;
    logic [N_AXES-1:0][FIELD_W-1:0] hi;
    logic                           vis;
  } fac_tok_t;

endpackage

### rtl/fac_box_if.sv
// fac_box_if: input channel carrying one axis-aligned box per item.
// Depends on fac_pkg.
interface fac_box_if
  import fac_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] box_min_x;
  logic signed [FIELD_W-1:0] box_min_y;
  logic signed [FIELD_W-1:0] box_min_z;
  logic signed [FIELD_W-1:0] box_max_x;
  logic signed [FIELD_W-1:0] box_max_y;
  logic signed [FIELD_W-1:0] box_max_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, output ready);
endinterface

### rtl/fac_vis_if.sv
// fac_vis_if: result channel carrying the visibility verdict per item.
// Depends on fac_pkg.
interface fac_vis_if
  import fac_pkg::*;
();
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

### rtl/fac_cfg_if.sv
// fac_cfg_if: configuration write channel (register index and data).
// Depends on fac_pkg.
interface fac_cfg_if
  import fac_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fac_cfg.sv
// fac_cfg: matrix register file and the six clip planes formed from it.
// Depends on fac_pkg and fac_cfg_if.
module fac_cfg
  import fac_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fac_cfg_if.sink               cfg,
  output logic signed [COORD_BITS:0] plane [N_PLANES][MAT_DIM]
);

  localparam int CB1 = COORD_BITS + 1;

  logic [CFG_W-1:0] mat_r [NUM_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) mat_r[i] <= MAT_RESET[i];
    end else if (cfg.valid && (cfg.index < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg.index[REG_IDX_W-1:0]] <= cfg.data;
    end
  end

  // Row r of the matrix lives in registers 2r (cols 1,2) and 2r+1 (cols 3,4)
  for (genvar r = 0; r < MAT_DIM; r++) begin : g_row
    logic signed [COORD_BITS-1:0] c1, c2, c3, c4;
    assign c1 = mat_r[2*r][COORD_BITS-1:0];
    assign c2 = mat_r[2*r][SLOT_W+COORD_BITS-1:SLOT_W];
    assign c3 = mat_r[2*r+1][COORD_BITS-1:0];
    assign c4 = mat_r[2*r+1][SLOT_W+COORD_BITS-1:SLOT_W];

    assign plane[PL_LEFT][r]   = CB1'(c4) + CB1'(c1);
    assign plane[PL_RIGHT][r]  = CB1'(c4) - CB1'(c1);
    assign plane[PL_BOTTOM][r] = CB1'(c4) + CB1'(c2);
    assign plane[PL_TOP][r]    = CB1'(c4) - CB1'(c2);
    assign plane[PL_NEAR][r]   = CB1'(c3);
    assign plane[PL_FAR][r]    = CB1'(c4) - CB1'(c3);
  end

endmodule

### rtl/fac_cell.sv
// fac_cell: one plane test in the chain; holds its plane, multiplies the
// far corner by the normal, then sums and folds the sign into the verdict.
// Depends on fac_pkg.
module fac_cell
  import fac_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [COORD_BITS:0] coef [MAT_DIM],
  input  logic                     up_vld,
  output logic                     up_rdy,
  input  fac_tok_t                 up_tok,
  output logic                     dn_vld,
  input  logic                     dn_rdy,
  output fac_tok_t                 dn_tok
);

  localparam int PROD_W = 2 * COORD_BITS + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [COORD_BITS:0]   plane_r [MAT_DIM];
  logic signed [COORD_BITS-1:0] crd     [N_AXES];
  logic signed [PROD_W-1:0]     prod_nxt [N_AXES];
  logic signed [PROD_W-1:0]     prod_r  [N_AXES];
  logic signed [COORD_BITS:0]   d_r;
  logic signed [SUM_W-1:0]      sum;
  logic                         vis_nxt;
  fac_tok_t                     tok_a_r, tok_b_r;
  logic                         vld_a_r, vld_b_r;
  logic                         rdy_a, rdy_b;

  assign rdy_b  = !vld_b_r || dn_rdy;
  assign rdy_a  = !vld_a_r || rdy_b;
  assign up_rdy = rdy_a;
  assign dn_vld = vld_b_r;
  assign dn_tok = tok_b_r;

  // Pick max where the normal component is nonnegative, min otherwise
  always_comb begin
    for (int k = 0; k < N_AXES; k++) begin
      crd[k] = plane_r[k][COORD_BITS] ? up_tok.lo[k][COORD_BITS-1:0]
                                      : up_tok.hi[k][COORD_BITS-1:0];
      prod_nxt[k] = PROD_W'(plane_r[k]) * PROD_W'(crd[k]);
    end
  end

  assign sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2])
             + (SUM_W'(d_r) <<< FRAC_BITS);
  assign vis_nxt = tok_a_r.vis && !sum[SUM_W-1];

  always_ff @(posedge clk) begin
    plane_r <= coef;
    if (rdy_a && up_vld) begin
      prod_r  <= prod_nxt;
      d_r     <= plane_r[MAT_DIM-1];
      tok_a_r <= up_tok;
    end
    if (rdy_b && vld_a_r) begin
      tok_b_r <= '{lo: tok_a_r.lo, hi: tok_a_r.hi, vis: vis_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (rdy_a) vld_a_r <= up_vld;
      if (rdy_b) vld_b_r <= vld_a_r;
    end
  end

endmodule

### rtl/frustum_aabb_cull_top.sv
// frustum_aabb_cull_top: view-frustum test of axis-aligned boxes.
// Depends on fac_pkg, the channel interfaces, fac_cfg and fac_cell.
//
// Usage:
//   cfg_wr  - matrix writes (index 0..7, rows 1..4, two Q16.16 entries per
//             64-bit word); always ready, indexes above 7 are dropped.
//             Write only while no box is in flight.
//   in_box  - one box (min and max corner) per item, valid/ready.
//   out_res - one verdict per box, visible = 0 when the box lies wholly
//             outside any of the six clip planes.
// Pipeline: one input register, then six plane cells of two stages each
// (multiply, then sum and sign). Throughput: one box per cycle while
// out_res is ready; each plane cell has its own three 33x32 multipliers.
// Reset (synchronous, rst_n low) loads the identity matrix and empties
// every stage. When out_res stalls, the last stage holds its item and the
// chain keeps accepting boxes until every stage is full; ready then drops.
module frustum_aabb_cull_top
  import fac_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fac_box_if.sink    in_box,
  fac_vis_if.source  out_res,
  fac_cfg_if.sink    cfg_wr
);

  logic signed [COORD_BITS:0] plane [N_PLANES][MAT_DIM];

  logic     lnk_vld [N_PLANES+1];
  logic     lnk_rdy [N_PLANES+1];
  fac_tok_t lnk_tok [N_PLANES+1];

  logic     in_vld_r;
  fac_tok_t in_tok_r;

  fac_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .plane (plane)
  );

  // Input register: lets the plane registers catch up after reset or a write
  assign in_box.ready = !in_vld_r || lnk_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_box.ready) begin
      in_vld_r <= in_box.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_box.valid && in_box.ready) begin
      in_tok_r <= '{lo:  {in_box.box_min_z, in_box.box_min_y, in_box.box_min_x},
                    hi:  {in_box.box_max_z, in_box.box_max_y, in_box.box_max_x},
                    vis: 1'b1};
    end
  end

  assign lnk_vld[0] = in_vld_r;
  assign lnk_tok[0] = in_tok_r;

  for (genvar i = 0; i < N_PLANES; i++) begin : g_cell
    fac_cell #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .coef   (plane[i]),
      .up_vld (lnk_vld[i]),
      .up_rdy (lnk_rdy[i]),
      .up_tok (lnk_tok[i]),
      .dn_vld (lnk_vld[i+1]),
      .dn_rdy (lnk_rdy[i+1]),
      .dn_tok (lnk_tok[i+1])
    );
  end

  assign lnk_rdy[N_PLANES] = out_res.ready;
  assign out_res.valid     = lnk_vld[N_PLANES];
  assign out_res.visible   = lnk_tok[N_PLANES].vis;

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_res.valid)
    else $error("result valid right after reset");

  a_entry_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_vld_r) |-> $past(in_box.valid && in_box.ready))
    else $error("input stage filled without an accepted item");

endmodule
